/* rtl/swr_pkg.sv */
// Shared constants for the stream word replace block: register codes,
// configuration port widths and the group queue depth. No dependencies.
package swr_pkg;

    // Byte and configuration port widths
    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_WORD        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LENGTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_WORD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    // Result group queue between the match stage and the output serializer
    localparam int GQ_DEPTH = 2;
    localparam int GQ_PTR_W = 1;

endpackage

/* rtl/swr_stream_if.sv */
// Valid/ready stream interfaces for the input text words and the result words.
// Depends on swr_pkg for the byte width.
interface swr_in_if;
    logic                       valid;
    logic                       ready;
    logic [swr_pkg::BYTE_W-1:0] text_byte;
    logic                       byte_present;
    logic                       line_end;

    modport source (output valid, text_byte, byte_present, line_end, input ready);
    modport sink   (input valid, text_byte, byte_present, line_end, output ready);
endinterface

interface swr_out_if;
    logic                       valid;
    logic                       ready;
    logic [swr_pkg::BYTE_W-1:0] out_byte;
    logic                       out_byte_valid;
    logic                       out_line_end;
    logic                       last_of_run;

    modport source (output valid, out_byte, out_byte_valid, out_line_end, last_of_run,
                    input ready);
    modport sink   (input valid, out_byte, out_byte_valid, out_line_end, last_of_run,
                    output ready);
endinterface

/* rtl/swr_cfg.sv */
// Configuration registers for the search and replacement words, with the
// length clamping and the window clear on search writes. Depends on swr_pkg.
module swr_cfg #(
    parameter int  MAX_WORD_BYTES = 8,
    localparam int CW             = $clog2(MAX_WORD_BYTES + 1),
    localparam int WW             = swr_pkg::BYTE_W * MAX_WORD_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [swr_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [swr_pkg::CFG_DATA_W-1:0] i_data,
    output logic [WW-1:0]                 o_sword,
    output logic [WW-1:0]                 o_rword,
    output logic [CW-1:0]                 o_slen,
    output logic [CW-1:0]                 o_rlen,
    output logic                          o_clr
);
    import swr_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD_BYTES);

    logic [WW-1:0]    r_sword;
    logic [WW-1:0]    r_rword;
    logic [LEN_W-1:0] r_slen;
    logic [LEN_W-1:0] r_rlen;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sword <= '0;
            r_rword <= '0;
            r_slen  <= LEN_W'(1);
            r_rlen  <= '0;
        end else if (i_we) begin
            unique case (i_idx)
                REG_SEARCH_WORD:        r_sword <= i_data[WW-1:0];
                REG_SEARCH_LENGTH:      r_slen  <= i_data[LEN_W-1:0];
                REG_REPLACEMENT_WORD:   r_rword <= i_data[WW-1:0];
                REG_REPLACEMENT_LENGTH: r_rlen  <= i_data[LEN_W-1:0];
                default:                r_slen  <= r_slen;
            endcase
        end
    end

    // Drop the pending window whenever the search word changes
    assign o_clr = i_we && (i_idx == REG_SEARCH_WORD || i_idx == REG_SEARCH_LENGTH);

    // Clamp lengths: search length at least one, both at most the word size
    always_comb begin
        if (r_slen == '0) begin
            o_slen = CW'(1);
        end else if (r_slen > MAX_LEN) begin
            o_slen = CW'(MAX_WORD_BYTES);
        end else begin
            o_slen = r_slen[CW-1:0];
        end
        if (r_rlen > MAX_LEN) begin
            o_rlen = CW'(MAX_WORD_BYTES);
        end else begin
            o_rlen = r_rlen[CW-1:0];
        end
    end

    assign o_sword = r_sword;
    assign o_rword = r_rword;

endmodule

/* rtl/swr_match.sv */
// Pending window and match logic: folds one input word into the window and
// builds the group of result bytes it causes. Depends on swr_pkg.
module swr_match #(
    parameter int  MAX_WORD_BYTES = 8,
    localparam int CW             = $clog2(MAX_WORD_BYTES + 1),
    localparam int WW             = swr_pkg::BYTE_W * MAX_WORD_BYTES,
    localparam int GW             = WW + CW + 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [WW-1:0]              i_sword,
    input  logic [WW-1:0]              i_rword,
    input  logic [CW-1:0]              i_slen,
    input  logic [CW-1:0]              i_rlen,
    input  logic                       i_clr,
    input  logic                       i_fire,
    input  logic [swr_pkg::BYTE_W-1:0] i_text_byte,
    input  logic                       i_byte_present,
    input  logic                       i_line_end,
    output logic                       o_push,
    output logic [GW-1:0]              o_grp
);
    import swr_pkg::*;

    logic [MAX_WORD_BYTES-1:0][BYTE_W-1:0] r_win;
    logic [CW-1:0]                         r_cnt;
    logic [MAX_WORD_BYTES-1:0][BYTE_W-1:0] n_win;
    logic [CW-1:0]                         n_cnt;

    logic [MAX_WORD_BYTES-1:0][BYTE_W-1:0] sword_b;
    logic [MAX_WORD_BYTES-1:0][BYTE_W-1:0] win_a;
    logic [CW-1:0]                         cnt_a;
    logic [CW-1:0]                         n_res;
    logic                                  full;
    logic                                  hit;
    logic                                  match;
    logic                                  bare;

    assign sword_b = i_sword;

    // Append the new byte and decide between replace, emit oldest and flush
    always_comb begin
        for (int j = 0; j < MAX_WORD_BYTES; j++) begin
            win_a[j] = (i_byte_present && r_cnt == CW'(j)) ? i_text_byte : r_win[j];
        end
        cnt_a = r_cnt + CW'(i_byte_present);
        full  = i_byte_present && (cnt_a >= i_slen);

        hit = 1'b1;
        for (int j = 0; j < MAX_WORD_BYTES; j++) begin
            if (CW'(j) < i_slen && win_a[j] != sword_b[j]) begin
                hit = 1'b0;
            end
        end
        match = full && hit;

        priority if (match) begin
            n_res = i_rlen;
        end else if (i_line_end) begin
            n_res = cnt_a;
        end else if (full) begin
            n_res = CW'(1);
        end else begin
            n_res = '0;
        end
        bare = i_line_end && (n_res == '0);

        priority if (i_line_end || match) begin
            n_win = '0;
            n_cnt = '0;
        end else if (full) begin
            n_win = win_a >> BYTE_W;
            n_cnt = cnt_a - CW'(1);
        end else begin
            n_win = win_a;
            n_cnt = cnt_a;
        end
    end

    // Pack the result group: line end, bare mark, byte count, bytes
    assign o_grp  = {i_line_end, bare, (bare ? CW'(1) : n_res),
                     (match ? i_rword : WW'(win_a))};
    assign o_push = i_fire && (n_res != '0 || i_line_end);

    // Advance the window on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_win <= '0;
            r_cnt <= '0;
        end else if (i_fire) begin
            r_win <= n_win;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/swr_gfifo.sv */
// Small queue of result groups between the match stage and the serializer.
// Depends on swr_pkg for its depth.
module swr_gfifo #(
    parameter int W = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_valid,
    output logic         o_full,
    output logic [W-1:0] o_data
);
    import swr_pkg::*;

    logic [W-1:0]        r_mem [GQ_DEPTH];
    logic [GQ_PTR_W-1:0] r_wp;
    logic [GQ_PTR_W-1:0] r_rp;
    logic [GQ_PTR_W:0]   r_cnt;

    // Hold entries and advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + GQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + GQ_PTR_W'(1);
            end
            r_cnt <= r_cnt + (GQ_PTR_W + 1)'(i_push) - (GQ_PTR_W + 1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (GQ_PTR_W + 1)'(GQ_DEPTH));
    assign o_data  = r_mem[r_rp];

endmodule

/* rtl/swr_serial.sv */
// Output serializer: holds one result group and hands out its bytes one word
// per cycle on the output stream while it is ready. Depends on swr_pkg and swr_out_if.
module swr_serial #(
    parameter int  MAX_WORD_BYTES = 8,
    localparam int CW             = $clog2(MAX_WORD_BYTES + 1),
    localparam int WW             = swr_pkg::BYTE_W * MAX_WORD_BYTES,
    localparam int GW             = WW + CW + 2,
    localparam int IW             = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_gvalid,
    input  logic [GW-1:0] i_grp,
    output logic          o_pop,
    swr_out_if.source     o_out
);
    import swr_pkg::*;

    logic [GW-1:0] r_grp;
    logic [IW-1:0] r_idx;
    logic          r_busy;

    logic [MAX_WORD_BYTES-1:0][BYTE_W-1:0] bytes_b;
    logic [CW-1:0]                         cnt;
    logic                                  bare;
    logic                                  eol;
    logic                                  last;
    logic                                  take;

    // Unpack the held group
    assign bytes_b = r_grp[WW-1:0];
    assign cnt     = r_grp[WW+CW-1:WW];
    assign bare    = r_grp[WW+CW];
    assign eol     = r_grp[WW+CW+1];
    assign last    = (CW'(r_idx) == cnt - CW'(1));

    // Load the next group when empty or when the last byte leaves
    assign take  = !r_busy || (o_out.ready && last);
    assign o_pop = take && i_gvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_busy <= i_gvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_grp <= i_grp;
            r_idx <= '0;
        end else if (o_out.ready) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // Drive the result word
    assign o_out.valid          = r_busy;
    assign o_out.out_byte       = bare ? '0 : bytes_b[r_idx];
    assign o_out.out_byte_valid = !bare;
    assign o_out.out_line_end   = eol && last;
    assign o_out.last_of_run    = last;

endmodule

/* rtl/stream_word_replace_unit.sv */
// Top level of the stream word replace block: configuration registers, match
// stage, group queue and output serializer. Depends on swr_pkg and the stream interfaces.
//
// Takes one text word per cycle and replaces every leftmost, non-overlapping
// occurrence of the search word by the replacement word, line by line. An
// accepted word is folded into the pending window in the cycle it is taken,
// and the result bytes it causes (none up to MAX_WORD_BYTES) enter a two-group
// queue, then the serializer register. The output moves one result word per
// cycle while it is ready, so the input runs at one word per cycle as long as
// each word causes at most one result on average; a word that causes k results
// holds the output for all k of them, and the input stalls once both queue
// slots are taken. Configuration writes to the search word or length empty the
// pending window; write registers only while the block is idle.
module stream_word_replace_unit #(
    parameter int MAX_WORD_BYTES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    swr_in_if.sink                         i_in,
    swr_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [swr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import swr_pkg::*;

    localparam int CW = $clog2(MAX_WORD_BYTES + 1);
    localparam int WW = BYTE_W * MAX_WORD_BYTES;
    localparam int GW = WW + CW + 2;

    logic [WW-1:0] sword;
    logic [WW-1:0] rword;
    logic [CW-1:0] slen;
    logic [CW-1:0] rlen;
    logic          clr;
    logic          fire;
    logic          push;
    logic [GW-1:0] grp_in;
    logic [GW-1:0] grp_out;
    logic          gq_valid;
    logic          gq_full;
    logic          pop;

    // Accept a word while the group queue has room
    assign i_in.ready = !gq_full;
    assign fire       = i_in.valid && i_in.ready;

    swr_cfg #(.MAX_WORD_BYTES(MAX_WORD_BYTES)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_sword (sword),
        .o_rword (rword),
        .o_slen  (slen),
        .o_rlen  (rlen),
        .o_clr   (clr)
    );

    swr_match #(.MAX_WORD_BYTES(MAX_WORD_BYTES)) u_match (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sword        (sword),
        .i_rword        (rword),
        .i_slen         (slen),
        .i_rlen         (rlen),
        .i_clr          (clr),
        .i_fire         (fire),
        .i_text_byte    (i_in.text_byte),
        .i_byte_present (i_in.byte_present),
        .i_line_end     (i_in.line_end),
        .o_push         (push),
        .o_grp          (grp_in)
    );

    swr_gfifo #(.W(GW)) u_gfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (grp_in),
        .i_pop   (pop),
        .o_valid (gq_valid),
        .o_full  (gq_full),
        .o_data  (grp_out)
    );

    swr_serial #(.MAX_WORD_BYTES(MAX_WORD_BYTES)) u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gvalid (gq_valid),
        .i_grp    (grp_out),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

/* rtl/swr_check.sv */
// Port-level checks on the result stream of the stream word replace block,
// bound to the top level. Depends on swr_pkg and stream_word_replace_unit.
module swr_check (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic [swr_pkg::BYTE_W-1:0] i_out_byte,
    input logic                       i_out_byte_valid,
    input logic                       i_out_line_end,
    input logic                       i_last_of_run
);
    import swr_pkg::*;

    // Hold a stalled result word
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result word dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=>
            $stable({i_out_byte, i_out_byte_valid, i_out_line_end, i_last_of_run}))
        else $error("result word changed while stalled");

    // A line end closes the run of the word that caused it
    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_out_line_end |-> i_last_of_run)
        else $error("line end on a word that is not last of its run");

    // A bare line end carries no character
    a_bare_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_out_byte_valid |->
            i_out_line_end && i_last_of_run && i_out_byte == '0)
        else $error("empty result word that is not a bare line end");

endmodule

bind stream_word_replace_unit swr_check u_swr_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_out.valid),
    .i_ready          (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_out_byte_valid (o_out.out_byte_valid),
    .i_out_line_end   (o_out.out_line_end),
    .i_last_of_run    (o_out.last_of_run)
);

/* bench/swr_result_checker.sv */
// Result checker for stream_word_replace_unit: watches both word channels and the
// register port, predicts every result word and compares it. Depends on swr_pkg
// and the stream interfaces in swr_stream_if.sv.
module swr_result_checker
    import swr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    swr_in_if                     i_text,
    swr_out_if                    i_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_words_waiting
);

    localparam int WORD_BYTES  = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              data_valid;
        logic              line_end;
        logic              run_last;
    } text_word_t;

    // Result words still owed by the block, oldest first
    text_word_t expected_words[$];

    // Shadow registers and the pending text window
    logic [CFG_DATA_W-1:0] search_word;
    logic [LEN_W-1:0]      search_len_reg;
    logic [CFG_DATA_W-1:0] replace_word;
    logic [LEN_W-1:0]      replace_len_reg;
    logic [63:0]           window;
    int                    window_fill;

    // Saturate a length register to the legal range
    function automatic int clamp_len(logic [LEN_W-1:0] raw, int lo);
        if (raw < lo)
            return lo;
        if (raw > WORD_BYTES)
            return WORD_BYTES;
        return int'(raw);
    endfunction

    // Print one line per mismatch and count it
    task automatic report_mismatch(string msg);
        o_fail_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Fold one text word into the window and queue the result words it causes
    task automatic predict_results(logic [BYTE_W-1:0] text_byte, logic present, logic eol);
        text_word_t run[$];
        int         slen;
        int         rlen;
        logic [63:0] match_mask;

        slen = clamp_len(search_len_reg, 1);
        rlen = clamp_len(replace_len_reg, 0);

        if (present) begin
            window = window | ({56'd0, text_byte} << (8 * (window_fill & 7)));
            window_fill++;
            if (window_fill >= slen) begin
                match_mask = (slen >= WORD_BYTES) ? '1 : ((64'd1 << (8 * slen)) - 64'd1);
                if (((window ^ search_word) & match_mask) == 64'd0) begin
                    // Full match: emit the replacement, empty the window
                    for (int k = 0; k < rlen; k++)
                        run.push_back('{replace_word[8*k +: 8], 1'b1, 1'b0, 1'b0});
                    window      = '0;
                    window_fill = 0;
                end else begin
                    // No match: release the oldest byte
                    run.push_back('{window[7:0], 1'b1, 1'b0, 1'b0});
                    window = window >> 8;
                    window_fill--;
                end
            end
        end

        if (eol) begin
            // Flush what is left of the line
            while (window_fill > 0 && run.size() < WORD_BYTES) begin
                run.push_back('{window[7:0], 1'b1, 1'b0, 1'b0});
                window = window >> 8;
                window_fill--;
            end
            window      = '0;
            window_fill = 0;
            if (run.size() == 0)
                run.push_back('{8'd0, 1'b0, 1'b0, 1'b0});
        end

        if (run.size() > 0) begin
            run[run.size()-1].run_last = 1'b1;
            if (eol)
                run[run.size()-1].line_end = 1'b1;
        end
        foreach (run[k])
            expected_words.push_back(run[k]);
    endtask

    // Compare one accepted result word with the oldest expectation
    task automatic check_result();
        text_word_t want;

        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("result word %02h with none expected",
                                      i_result.out_byte));
        end else begin
            want = expected_words.pop_front();
            if (i_result.out_byte !== want.data)
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                                          i_result.out_byte, want.data));
            if (i_result.out_byte_valid !== want.data_valid)
                report_mismatch($sformatf("out_byte_valid %b, expected %b",
                                          i_result.out_byte_valid, want.data_valid));
            if (i_result.out_line_end !== want.line_end)
                report_mismatch($sformatf("out_line_end %b, expected %b",
                                          i_result.out_line_end, want.line_end));
            if (i_result.last_of_run !== want.run_last)
                report_mismatch($sformatf("last_of_run %b, expected %b",
                                          i_result.last_of_run, want.run_last));
        end
    endtask

    // Track register writes; search changes drop the window
    task automatic apply_write();
        case (i_cfg_idx)
            REG_SEARCH_WORD: begin
                search_word = i_cfg_data;
                window      = '0;
                window_fill = 0;
            end
            REG_SEARCH_LENGTH: begin
                search_len_reg = i_cfg_data[LEN_W-1:0];
                window         = '0;
                window_fill    = 0;
            end
            REG_REPLACEMENT_WORD: begin
                replace_word = i_cfg_data;
            end
            REG_REPLACEMENT_LENGTH: begin
                replace_len_reg = i_cfg_data[LEN_W-1:0];
            end
            default: ;
        endcase
    endtask

    // Check results before predicting, so a result can never meet its own prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            search_word     = '0;
            search_len_reg  = 4'd1;
            replace_word    = '0;
            replace_len_reg = 4'd0;
            window          = '0;
            window_fill     = 0;
            o_fail_count    = 0;
            expected_words.delete();
            o_words_waiting <= 0;
        end else begin
            if (i_result.valid && i_result.ready)
                check_result();
            if (i_cfg_we)
                apply_write();
            if (i_text.valid && i_text.ready)
                predict_results(i_text.text_byte, i_text.byte_present, i_text.line_end);
            o_words_waiting <= expected_words.size();
        end
    end

endmodule

/* bench/tb_stream_word_replace_unit.sv */
// Testbench top for stream_word_replace_unit: clock, reset, text stimulus, result
// back-pressure, register writes and the verdict. Depends on swr_pkg, the stream
// interfaces and swr_result_checker.
module tb_stream_word_replace_unit;
    import swr_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 10;
    localparam int IDLE_LIMIT    = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bit quiet;
    int fail_count;
    int words_waiting;
    int idle_cycles = 0;

    swr_in_if  text_ch ();
    swr_out_if result_ch ();

    stream_word_replace_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (text_ch),
        .o_out      (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    swr_result_checker replace_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_text          (text_ch),
        .i_result        (result_ch),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_words_waiting (words_waiting)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result channel in random bursts, none once the run goes quiet
    initial begin
        int stall_left;
        int run_left;

        stall_left = 0;
        run_left   = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet) begin
                result_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else if (run_left > 0) begin
                result_ch.ready <= 1'b1;
                run_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                result_ch.ready <= 1'b0;
            end else begin
                run_left = $urandom_range(1, 24) - 1;
                result_ch.ready <= 1'b1;
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("stream_word_replace_unit test failed");
            $finish;
        end
    end

    // Pack a string into a word register, first character in the low byte
    function automatic logic [63:0] pack_text(string s);
        logic [63:0] w;

        w = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            w[8*i +: 8] = s[i];
        return w;
    endfunction

    // Offer one text word, with an optional random gap first, and hold it until taken
    task automatic send_word(logic [7:0] text_byte, logic present, logic eol);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        text_ch.valid        <= 1'b1;
        text_ch.text_byte    <= text_byte;
        text_ch.byte_present <= present;
        text_ch.line_end     <= eol;
        do @(posedge i_clk); while (!text_ch.ready);
    endtask

    task automatic send_text(string s, bit eol);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b1, eol && (i == s.len() - 1));
    endtask

    // Hold the input until every expected result word is out, then let the block settle
    task automatic wait_for_results();
        text_ch.valid <= 1'b0;
        do @(posedge i_clk); while (words_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back; the block must be idle
    task automatic set_config(logic [63:0] sw, logic [63:0] slen,
                              logic [63:0] rw, logic [63:0] rlen);
        logic [CFG_IDX_W-1:0]  reg_idx [4];
        logic [CFG_DATA_W-1:0] reg_val [4];

        reg_idx = '{REG_SEARCH_WORD, REG_SEARCH_LENGTH,
                    REG_REPLACEMENT_WORD, REG_REPLACEMENT_LENGTH};
        reg_val = '{sw, slen, rw, rlen};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= reg_idx[r];
            i_cfg_data <= reg_val[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // One random phase: a search word over a small alphabet, text that mostly
    // hits it, some noise, and one full drain halfway through
    task automatic random_phase(int n_items, logic [3:0] slen_raw, logic [3:0] rlen_raw);
        logic [7:0]  alphabet [3];
        logic [63:0] sw;
        int          slen;
        int          sent;
        int          r;
        bit          drained;

        slen = (slen_raw == 0) ? 1 : (slen_raw > 8) ? 8 : int'(slen_raw);
        foreach (alphabet[a])
            alphabet[a] = 8'($urandom_range(0, 255));
        for (int k = 0; k < 8; k++)
            sw[8*k +: 8] = (k < slen) ? alphabet[$urandom_range(0, 2)]
                                      : 8'($urandom_range(0, 255));

        wait_for_results();
        set_config(sw, {$urandom(), 28'($urandom()), slen_raw},
                   {$urandom(), $urandom()}, {$urandom(), 28'($urandom()), rlen_raw});

        sent    = 0;
        drained = 1'b0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                for (int k = 0; k < slen; k++)
                    send_word(sw[8*k +: 8], 1'b1,
                              (k == slen - 1) && ($urandom_range(0, 3) == 0));
                sent += slen;
            end else if (r < 85) begin
                send_word(alphabet[$urandom_range(0, 2)], 1'b1, $urandom_range(0, 9) == 0);
                sent++;
            end else if (r < 93) begin
                send_word(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 9) == 0);
                sent++;
            end else if (r < 97) begin
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                sent++;
            end else begin
                // no byte and no line end: ignored by the block
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            if (!drained && sent >= n_items / 2) begin
                wait_for_results();
                drained = 1'b1;
            end
        end
    endtask

    initial begin
        quiet = 1'b0;
        text_ch.valid        <= 1'b0;
        text_ch.text_byte    <= '0;
        text_ch.byte_present <= 1'b0;
        text_ch.line_end     <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= REG_SEARCH_WORD;
        i_cfg_data           <= '0;
        i_rst_n              <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: every zero byte is deleted, so lines can come out empty
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h41, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h5A, 1'b0, 1'b0);

        // Growing replacement, match after a false start, flush at line end
        wait_for_results();
        set_config(pack_text("ab"), 64'd2, pack_text("XYZ"), 64'd3);
        send_text("aaba", 1'b1);

        // Overlapping candidates: only the leftmost one is replaced
        wait_for_results();
        set_config(pack_text("aa"), 64'd2, pack_text("b"), 64'd1);
        send_text("aaa", 1'b1);

        // Full-size words with saturating lengths: eight result words at once
        wait_for_results();
        set_config(pack_text("abcdefgh"), 64'd15, pack_text("01234567"), 64'd15);
        send_text("abcdefgh", 1'b1);

        // Zero search length acts as one byte; junk above it is ignored; matches vanish
        wait_for_results();
        set_config(64'hA5A5_A5A5_A5A5_A500 | pack_text("z"), 64'd0,
                   64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_text("zz", 1'b1);

        random_phase(30, 4'd3, 4'd2);
        random_phase(30, 4'd1, 4'd8);
        random_phase(30, 4'd8, 4'd0);
        random_phase(30, 4'd0, 4'd15);
        random_phase(30, 4'd12, 4'd1);
        wait_for_results();
        quiet = 1'b1;
        random_phase(30, 4'($urandom_range(1, 8)), 4'($urandom_range(0, 8)));

        // Drain and give late or extra result words a chance to show
        text_ch.valid <= 1'b0;
        do @(posedge i_clk); while (words_waiting != 0);
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("stream_word_replace_unit test passed");
        else
            $display("stream_word_replace_unit test failed");
        $finish;
    end

endmodule
